FILE: design/neighbour_mean_min_max_std_aggregator_assert.svh
// assertion macros for the neighbour aggregator
`ifndef NEIGHBOUR_MEAN_MIN_MAX_STD_AGGREGATOR_ASSERT_SVH
`define NEIGHBOUR_MEAN_MIN_MAX_STD_AGGREGATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define NMAG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define NMAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/nmag_pkg.sv
// shared constants and types of the neighbour aggregator
package nmag_pkg;

	localparam int NODES   = 256;
	localparam int DIMS    = 80;
	localparam int ENTRIES = NODES * DIMS;
	localparam int NODE_W  = $clog2(NODES);
	localparam int DIM_W   = 7;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = 13;
	localparam int ACC_W   = 48;
	localparam int VAL_W   = 32;
	localparam int STD_W   = 31;
	localparam int EPS_W   = 16;
	localparam int WORD_W  = 2 * ACC_W + 2 * VAL_W;
	localparam int DIVC_W  = $clog2(ACC_W);

	localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
	localparam logic [EPS_W-1:0] EPS_RESET      = 16'd1;
	localparam logic [VAL_W-1:0] MIN_RESET      = 32'sd655360;
	localparam logic [VAL_W-1:0] MAX_RESET      = -32'sd655360;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ACC   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_EPS  = 2'd0,
		CFG_MIN  = 2'd1,
		CFG_MAX  = 2'd2,
		CFG_NONE = 2'd3
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RO_RD,
		ST_RO_LOAD,
		ST_RO_DIV,
		ST_RO_MUL,
		ST_RO_VAR,
		ST_RO_SQRT,
		ST_RO_OUT
	} state_t;

endpackage

FILE: design/nmag_ram.sv
// generic single-port ram with registered read
module nmag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: design/neighbour_mean_min_max_std_aggregator.sv
// top level of the neighbour mean, min, max and std aggregator
// Per node and dimension the block keeps sum, sum of squares, min and max of Q16.16
// message elements in one wide ram word, plus an edge count per node. An item is
// taken from the stream port only in the idle state. A clear item (tuser 0) and the
// reset both start a clearing pass that walks every one of the 20480 ram entries,
// one per cycle; configuration writes are taken during that pass, and min_start and
// max_start as they were when the pass began are used for it. An accumulate item
// (tuser 1) goes through accept with the squaring multiply, ram read, then
// read-modify-write. A readout item (tuser 2) with a nonzero edge count goes through
// accept, ram read, load, two 48-step passes of the shared restoring divider (mean
// and mean square), a multiply on the shared multiplier, the variance, 32 steps of
// the digit-by-digit square root and the output load; with zero edges the divider is
// skipped. Out-of-range readouts go from accept straight to the output load and
// return all zeros. The result sits in an output register, so the next item is
// accepted while it waits; a following readout holds in its last cycle until that
// register is free.
module neighbour_mean_min_max_std_aggregator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,   // node[7:0], dim[14:8], value[46:15], zero pad
	input  logic [1:0]   s_axis_tuser,   // mode[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,   // mean[31:0], min[63:32], max[95:64],
	                                     // std[126:96], edge_count[139:127], zero pad
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NW = nmag_pkg::NODE_W;
	localparam int DW = nmag_pkg::DIM_W;
	localparam int IW = nmag_pkg::IDX_W;
	localparam int CW = nmag_pkg::CNT_W;
	localparam int AW = nmag_pkg::ACC_W;
	localparam int VW = nmag_pkg::VAL_W;
	localparam int DIVC_W_L = nmag_pkg::DIVC_W;

	// configuration registers
	logic [nmag_pkg::EPS_W-1:0] eps_q;
	logic signed [VW-1:0]       min_start_q, max_start_q;
	// start values latched for the running clearing pass
	logic signed [VW-1:0]       clr_min_q, clr_max_q;

	nmag_pkg::state_t state_q, state_d;
	logic [IW-1:0]    clr_q;

	// request fields
	logic [NW-1:0]        in_node;
	logic [DW-1:0]        in_dim;
	logic signed [VW-1:0] in_value;
	logic                 in_ok;
	logic [IW-1:0]        in_idx;
	logic                 accept;

	assign in_node  = s_axis_tdata[7:0];
	assign in_dim   = s_axis_tdata[14:8];
	assign in_value = s_axis_tdata[46:15];
	assign in_ok    = (32'(in_node) < 32'(nmag_pkg::NODES)) &&
	                  (32'(in_dim) < 32'(nmag_pkg::DIMS));
	assign in_idx   = IW'(in_node) * IW'(nmag_pkg::DIMS) + IW'(in_dim);
	assign accept   = s_axis_tvalid && s_axis_tready;

	// latched item
	logic [IW-1:0]        idx_q;
	logic [NW-1:0]        node_q;
	logic                 dim0_q;
	logic signed [VW-1:0] value_q;

	// rams
	logic                           ram_we, cnt_we;
	logic [IW-1:0]                  ram_addr;
	logic [nmag_pkg::WORD_W-1:0]    ram_wdata, ram_rdata;
	logic [NW-1:0]                  cnt_addr;
	logic [CW-1:0]                  cnt_wdata, cnt_rdata;

	logic signed [AW-1:0] rd_sum, rd_sq;
	logic signed [VW-1:0] rd_min, rd_max;
	assign rd_sum = ram_rdata[AW-1:0];
	assign rd_sq  = ram_rdata[2*AW-1:AW];
	assign rd_min = ram_rdata[2*AW+VW-1:2*AW];
	assign rd_max = ram_rdata[2*AW+2*VW-1:2*AW+VW];

	// shared multiplier, registered product
	logic signed [VW-1:0]   mul_a, mean32;
	logic signed [2*VW-1:0] prod_q;
	assign mul_a = (state_q == nmag_pkg::ST_IDLE) ? in_value : mean32;

	// accumulate datapath
	logic signed [AW:0]   sum_ext, sq_ext;
	logic signed [AW-1:0] sum_new, sq_new;
	logic signed [VW-1:0] min_new, max_new;
	logic [AW-1:0]        sq_add;

	assign sq_add  = prod_q[2*VW-1:16];
	assign sum_ext = {rd_sum[AW-1], rd_sum} + {{(AW+1-VW){value_q[VW-1]}}, value_q};
	assign sq_ext  = {rd_sq[AW-1], rd_sq} + {1'b0, sq_add};

	function automatic logic signed [AW-1:0] sat48(input logic signed [AW:0] v);
		logic signed [AW-1:0] r;
		r = v[AW-1:0];
		if (v[AW] != v[AW-1]) begin
			r = v[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end
		sat48 = r;
	endfunction

	assign sum_new = sat48(sum_ext);
	assign sq_new  = sat48(sq_ext);
	assign min_new = (value_q <= rd_min) ? value_q : rd_min;
	assign max_new = (value_q >= rd_max) ? value_q : rd_max;

	// readout datapath
	logic signed [VW-1:0] min_q, max_q;
	logic [CW-1:0]        cnt_q;
	logic signed [AW-1:0] sq_q, mean_q, meansq_q;
	logic                 zero_q;

	// shared restoring divider: magnitude / count
	logic [AW-1:0]     div_dq_q;
	logic [CW-1:0]     div_rem_q;
	logic [DIVC_W_L-1:0] div_cnt_q;
	logic              div_neg_q, div_pass_q;
	logic [CW:0]       div_trial, div_diff;
	logic              div_ge;
	logic [AW-1:0]     div_quot;
	logic signed [AW-1:0] div_res;

	assign div_trial = {div_rem_q, div_dq_q[AW-1]};
	assign div_ge    = div_trial >= {1'b0, cnt_q};
	assign div_diff  = div_trial - {1'b0, cnt_q};
	assign div_quot  = {div_dq_q[AW-2:0], div_ge};
	assign div_res   = div_neg_q ? -$signed(div_quot) : $signed(div_quot);

	function automatic logic [AW-1:0] mag48(input logic signed [AW-1:0] v);
		mag48 = v[AW-1] ? AW'(-v) : AW'(v);
	endfunction

	// mean saturated to 32 bits
	logic signed [AW-1:0] mean_hi_lim, mean_lo_lim;
	assign mean_hi_lim = AW'(32'sh7fffffff);
	assign mean_lo_lim = {{(AW-VW+1){1'b1}}, {(VW-1){1'b0}}};
	assign mean32 = (mean_q > mean_hi_lim) ? VW'(mean_hi_lim) :
	                (mean_q < mean_lo_lim) ? VW'(mean_lo_lim) : mean_q[VW-1:0];

	// variance and square root unit
	logic signed [AW:0] var_raw, var_eps;
	logic signed [VW-1:0] mean_sat_q;
	assign var_raw = {1'b0, meansq_q} - {1'b0, prod_q[2*VW-1:16]};
	assign var_eps = (var_raw[AW] ? '0 : var_raw) + (AW+1)'(eps_q);

	logic [63:0] sq_x_q, sq_r_q, sq_bit_q, sq_t;
	logic        sq_ge;
	assign sq_t  = sq_r_q + sq_bit_q;
	assign sq_ge = sq_x_q >= sq_t;

	logic [nmag_pkg::STD_W-1:0] std_res;
	assign std_res = (sq_r_q[63:nmag_pkg::STD_W] != '0) ? '1 : sq_r_q[nmag_pkg::STD_W-1:0];

	// output register
	logic         out_valid_q;
	logic [143:0] out_data_q;
	logic         out_load;
	assign out_load      = (state_q == nmag_pkg::ST_RO_OUT) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	nmag_ram #(.WIDTH(nmag_pkg::WORD_W), .DEPTH(nmag_pkg::ENTRIES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	nmag_ram #(.WIDTH(CW), .DEPTH(nmag_pkg::NODES)) u_count (
		.clk   (clk),
		.we    (cnt_we),
		.addr  (cnt_addr),
		.wdata (cnt_wdata),
		.rdata (cnt_rdata)
	);

	// next state and ram controls
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_addr      = idx_q;
		ram_wdata     = {max_new, min_new, sq_new, sum_new};
		cnt_we        = 1'b0;
		cnt_addr      = node_q;
		cnt_wdata     = cnt_rdata + CW'(1);
		case (state_q)
			nmag_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = {clr_max_q, clr_min_q, {AW{1'b0}}, {AW{1'b0}}};
				cnt_we    = 32'(clr_q) < 32'(nmag_pkg::NODES);
				cnt_addr  = clr_q[NW-1:0];
				cnt_wdata = '0;
				if (32'(clr_q) == 32'(nmag_pkg::ENTRIES - 1)) begin
					state_d = nmag_pkg::ST_IDLE;
				end
			end
			nmag_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (nmag_pkg::mode_t'(s_axis_tuser))
						nmag_pkg::MODE_CLEAR: state_d = nmag_pkg::ST_CLEAR;
						nmag_pkg::MODE_ACC:   state_d = in_ok ? nmag_pkg::ST_ACC_RD
						                                      : nmag_pkg::ST_IDLE;
						nmag_pkg::MODE_READ:  state_d = in_ok ? nmag_pkg::ST_RO_RD
						                                      : nmag_pkg::ST_RO_OUT;
						default:              state_d = nmag_pkg::ST_IDLE;
					endcase
				end
			end
			nmag_pkg::ST_ACC_RD: state_d = nmag_pkg::ST_ACC_WR;
			nmag_pkg::ST_ACC_WR: begin
				ram_we  = 1'b1;
				cnt_we  = dim0_q && (cnt_rdata != nmag_pkg::COUNT_MAX);
				state_d = nmag_pkg::ST_IDLE;
			end
			nmag_pkg::ST_RO_RD:   state_d = nmag_pkg::ST_RO_LOAD;
			nmag_pkg::ST_RO_LOAD: state_d = (cnt_rdata == '0) ? nmag_pkg::ST_RO_MUL
			                                                  : nmag_pkg::ST_RO_DIV;
			nmag_pkg::ST_RO_DIV: begin
				if (32'(div_cnt_q) == AW - 1 && div_pass_q) begin
					state_d = nmag_pkg::ST_RO_MUL;
				end
			end
			nmag_pkg::ST_RO_MUL:  state_d = nmag_pkg::ST_RO_VAR;
			nmag_pkg::ST_RO_VAR:  state_d = nmag_pkg::ST_RO_SQRT;
			nmag_pkg::ST_RO_SQRT: begin
				if (sq_bit_q[0]) begin
					state_d = nmag_pkg::ST_RO_OUT;
				end
			end
			nmag_pkg::ST_RO_OUT: begin
				if (out_load) begin
					state_d = nmag_pkg::ST_IDLE;
				end
			end
			default: state_d = nmag_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nmag_pkg::ST_CLEAR;
			clr_q       <= '0;
			clr_min_q   <= nmag_pkg::MIN_RESET;
			clr_max_q   <= nmag_pkg::MAX_RESET;
			eps_q       <= nmag_pkg::EPS_RESET;
			min_start_q <= nmag_pkg::MIN_RESET;
			max_start_q <= nmag_pkg::MAX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (nmag_pkg::cfg_t'(cfg_index))
					nmag_pkg::CFG_EPS: eps_q       <= cfg_data[nmag_pkg::EPS_W-1:0];
					nmag_pkg::CFG_MIN: min_start_q <= cfg_data;
					nmag_pkg::CFG_MAX: max_start_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == nmag_pkg::ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end else begin
				clr_q <= '0;
			end
			// clear request: snapshot start values for the pass
			if (accept && nmag_pkg::mode_t'(s_axis_tuser) == nmag_pkg::MODE_CLEAR) begin
				clr_min_q <= min_start_q;
				clr_max_q <= max_start_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			nmag_pkg::ST_IDLE: begin
				prod_q  <= mul_a * mul_a;
				idx_q   <= in_idx;
				node_q  <= in_node;
				dim0_q  <= (in_dim == '0);
				value_q <= in_value;
				zero_q  <= !in_ok;
			end
			nmag_pkg::ST_RO_LOAD: begin
				cnt_q     <= cnt_rdata;
				min_q     <= rd_min;
				max_q     <= rd_max;
				sq_q      <= rd_sq;
				mean_q    <= rd_sum;
				meansq_q  <= rd_sq;
				div_dq_q  <= mag48(rd_sum);
				div_neg_q <= rd_sum[AW-1];
				div_rem_q <= '0;
				div_cnt_q <= '0;
				div_pass_q <= 1'b0;
			end
			nmag_pkg::ST_RO_DIV: begin
				div_rem_q <= div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
				div_dq_q  <= div_quot;
				div_cnt_q <= div_cnt_q + DIVC_W_L'(1);
				if (32'(div_cnt_q) == AW - 1) begin
					div_cnt_q <= '0;
					div_rem_q <= '0;
					if (!div_pass_q) begin
						mean_q     <= div_res;
						div_dq_q   <= mag48(sq_q);
						div_neg_q  <= sq_q[AW-1];
						div_pass_q <= 1'b1;
					end else begin
						meansq_q <= div_res;
					end
				end
			end
			nmag_pkg::ST_RO_MUL: begin
				mean_sat_q <= mean32;
				prod_q     <= mul_a * mul_a;
			end
			nmag_pkg::ST_RO_VAR: begin
				sq_x_q   <= {var_eps[AW-1:0], 16'd0};
				sq_r_q   <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			nmag_pkg::ST_RO_SQRT: begin
				if (sq_ge) begin
					sq_x_q <= sq_x_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			nmag_pkg::ST_RO_OUT: begin
				if (out_load) begin
					if (zero_q) begin
						out_data_q <= '0;
					end else begin
						out_data_q <= {4'd0, cnt_q, std_res, max_q, min_q, mean_sat_q};
					end
				end
			end
			default: ;
		endcase
	end

	`include "neighbour_mean_min_max_std_aggregator_assert.svh"

	`NMAG_ASSERT_NOW(a_busy_not_ready, state_q != nmag_pkg::ST_IDLE, !s_axis_tready, "ready while busy")
	`NMAG_ASSERT_NEXT(a_acc_read, accept && s_axis_tuser == nmag_pkg::MODE_ACC && in_ok, state_q == nmag_pkg::ST_ACC_RD, "accumulate did not start")
	`NMAG_ASSERT_NOW(a_sqrt_bit, state_q == nmag_pkg::ST_RO_SQRT, $onehot(sq_bit_q), "root bit lost")
	`NMAG_ASSERT_NOW(a_ram_write, ram_we, state_q == nmag_pkg::ST_CLEAR || state_q == nmag_pkg::ST_ACC_WR, "stray store write")

endmodule

FILE: test/aggregator_checker.sv
// scoreboard of the neighbour aggregator: request decode, prediction and result compare
`timescale 1ns / 1ps

module aggregator_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [143:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending,
	output int           checked
);

	typedef struct {
		logic [31:0] mean_q;
		logic [31:0] min_q;
		logic [31:0] max_q;
		logic [30:0] std_q;
		logic [12:0] edges_q;
	} stats_t;

	localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_LO = -S48_HI - 1;

	longint sum_mem [nmag_pkg::ENTRIES];
	longint sq_mem  [nmag_pkg::ENTRIES];
	longint lo_mem  [nmag_pkg::ENTRIES];
	longint hi_mem  [nmag_pkg::ENTRIES];
	int     edge_mem [nmag_pkg::NODES];
	longint eps_val, lo_start, hi_start;
	stats_t expected_stats [$];

	function automatic longint clamp48(longint v);
		if (v > S48_HI) return S48_HI;
		if (v < S48_LO) return S48_LO;
		return v;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void wipe_stores();
		for (int i = 0; i < nmag_pkg::ENTRIES; i++) begin
			sum_mem[i] = 0;
			sq_mem[i]  = 0;
			lo_mem[i]  = lo_start;
			hi_mem[i]  = hi_start;
		end
		for (int n = 0; n < nmag_pkg::NODES; n++) edge_mem[n] = 0;
	endfunction

	function automatic void fold_message(int n, int d, longint v);
		int i;
		i = n * nmag_pkg::DIMS + d;
		sum_mem[i] = clamp48(sum_mem[i] + v);
		sq_mem[i]  = clamp48(sq_mem[i] + ((v * v) >>> 16));
		if (v <= lo_mem[i]) lo_mem[i] = v;
		if (v >= hi_mem[i]) hi_mem[i] = v;
		if (d == 0 && edge_mem[n] < nmag_pkg::COUNT_MAX) edge_mem[n]++;
	endfunction

	function automatic stats_t node_stats(int n, int d);
		stats_t s;
		longint c, mean, msq, var_q;
		longint unsigned sd;
		int i;
		s = '{default: '0};
		if (d >= nmag_pkg::DIMS) return s;
		i = n * nmag_pkg::DIMS + d;
		c = edge_mem[n];
		mean = sum_mem[i];
		msq = sq_mem[i];
		// zero edges: sums go out undivided
		if (c != 0) begin
			mean = mean / c;
			msq = msq / c;
		end
		if (mean > 64'sd2147483647) mean = 64'sd2147483647;
		if (mean < -64'sd2147483648) mean = -64'sd2147483648;
		var_q = msq - ((mean * mean) >>> 16);
		if (var_q < 0) var_q = 0;
		var_q += eps_val;
		sd = root_floor(longint'(unsigned'(var_q)) << 16);
		if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
		s.mean_q  = mean[31:0];
		s.min_q   = lo_mem[i][31:0];
		s.max_q   = hi_mem[i][31:0];
		s.std_q   = sd[30:0];
		s.edges_q = c[12:0];
		return s;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t w;
		nmag_pkg::mode_t m;
		int n, d;
		if (!arst_n) begin
			eps_val = nmag_pkg::EPS_RESET;
			lo_start = longint'($signed(nmag_pkg::MIN_RESET));
			hi_start = longint'($signed(nmag_pkg::MAX_RESET));
			wipe_stores();
			expected_stats.delete();
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			// result side first: it belongs to an older request
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_stats.size() == 0) begin
					report("unexpected result", m_axis_tdata[31:0], '0);
				end else begin
					w = expected_stats.pop_front();
					checked++;
					if (m_axis_tdata[31:0] !== w.mean_q) report("mean", m_axis_tdata[31:0], w.mean_q);
					if (m_axis_tdata[63:32] !== w.min_q) report("min", m_axis_tdata[63:32], w.min_q);
					if (m_axis_tdata[95:64] !== w.max_q) report("max", m_axis_tdata[95:64], w.max_q);
					if (m_axis_tdata[126:96] !== w.std_q)
						report("std", {1'b0, m_axis_tdata[126:96]}, {1'b0, w.std_q});
					if (m_axis_tdata[139:127] !== w.edges_q)
						report("edge count", m_axis_tdata[139:127], w.edges_q);
				end
			end
			if (cfg_we) begin
				case (nmag_pkg::cfg_t'(cfg_index))
					nmag_pkg::CFG_EPS: eps_val = cfg_data[15:0];
					nmag_pkg::CFG_MIN: lo_start = longint'($signed(cfg_data));
					nmag_pkg::CFG_MAX: hi_start = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				m = nmag_pkg::mode_t'(s_axis_tuser);
				n = s_axis_tdata[7:0];
				d = s_axis_tdata[14:8];
				case (m)
					nmag_pkg::MODE_CLEAR: wipe_stores();
					nmag_pkg::MODE_ACC: begin
						if (d < nmag_pkg::DIMS)
							fold_message(n, d, longint'($signed(s_axis_tdata[46:15])));
					end
					nmag_pkg::MODE_READ: expected_stats.push_back(node_stats(n, d));
					default: ;
				endcase
			end
			pending = expected_stats.size();
		end
	end

endmodule

FILE: test/testbench.sv
// top of the neighbour aggregator testbench: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module testbench;

	// clearing pass is one ram entry per cycle, so this covers any clear in flight
	localparam int CLEAR_WAIT = nmag_pkg::ENTRIES + 600;
	localparam int CYCLE_LIMIT = 3_000_000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata = '0;   // node[7:0], dim[14:8], value[46:15], zero pad
	logic [1:0]   s_axis_tuser = '0;   // mode[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;        // mean, min, max, std[126:96], edge_count[139:127]
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	int fail_count, pending, checked;
	int send_idle, recv_idle;   // percent of cycles each side sits out
	int hold_off;               // long receiver stall requested by the stimulus
	int sent;
	longint cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	neighbour_mean_min_max_std_aggregator dut (.*);

	aggregator_checker scoreboard (.*);

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, pending);
			$display("neighbour_mean_min_max_std_aggregator verification failed");
			$finish;
		end
	end

	// receiver pacing, with its own countdown for the long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_axis_tready = 1'b0;
			hold_off--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_idle);
		end
	end

	// offer one request and hold it until the block takes it
	task automatic send(nmag_pkg::mode_t m, int node, int d, logic [31:0] val);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = m;
		s_axis_tdata = {1'b0, val, d[6:0], node[7:0]};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(nmag_pkg::cfg_t r, logic [31:0] v);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drain all readouts, then wait out any clearing pass before touching registers
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (CLEAR_WAIT) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0003_FFFF);
			3: return -$urandom_range(32'h0003_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// mostly a few hot entries so stores build up, some spread and some out of range
	task automatic random_requests(int count);
		int node, d, k;
		nmag_pkg::mode_t m;
		repeat (count) begin
			k = $urandom_range(99);
			m = (k < 66) ? nmag_pkg::MODE_ACC : (k < 97) ? nmag_pkg::MODE_READ
			                                             : nmag_pkg::MODE_NONE;
			node = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(255);
			k = $urandom_range(9);
			d = (k < 7) ? $urandom_range(3) : (k < 8) ? $urandom_range(127, 80) : $urandom_range(79);
			send(m, node, d, pick_value());
		end
	endtask

	initial begin
		send_idle = 38;
		recv_idle = 86;
		hold_off = 0;
		sent = 0;
		cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// eps gets a new value right away, the reset pass keeps the reset min/max starts
		write_reg(nmag_pkg::CFG_EPS, 32'd3);

		// directed: extremes, every mode, edge cases
		send(nmag_pkg::MODE_READ, 0, 0, '0);                 // untouched entry, zero edges
		send(nmag_pkg::MODE_ACC, 0, 0, 32'h7FFF_FFFF);
		send(nmag_pkg::MODE_ACC, 0, 0, 32'h7FFF_FFFF);       // square sum nears its limit, the next message saturates it
		send(nmag_pkg::MODE_ACC, 0, 0, 32'h8000_0000);
		send(nmag_pkg::MODE_READ, 0, 0, '0);
		send(nmag_pkg::MODE_ACC, 255, 79, 32'hFFFF_FFFF);
		send(nmag_pkg::MODE_READ, 255, 79, '0);              // zero edges, sums undivided
		send(nmag_pkg::MODE_ACC, 255, 0, 32'h0001_0000);
		send(nmag_pkg::MODE_READ, 255, 79, '0);
		send(nmag_pkg::MODE_ACC, 5, 80, 32'h1234_5678);      // out of range, ignored
		send(nmag_pkg::MODE_ACC, 5, 127, 32'h1234_5678);
		send(nmag_pkg::MODE_READ, 5, 80, '0);                // out of range, all-zero result
		send(nmag_pkg::MODE_READ, 170, 127, '0);
		send(nmag_pkg::MODE_NONE, 85, 42, 32'hAAAA_5555);    // unused mode, ignored
		send(nmag_pkg::MODE_ACC, 9, 1, 32'h000A_0000);       // exactly equal to min start
		send(nmag_pkg::MODE_ACC, 9, 2, 32'hFFF6_0000);       // exactly equal to max start
		send(nmag_pkg::MODE_READ, 9, 1, '0);
		send(nmag_pkg::MODE_READ, 9, 2, '0);
		send(nmag_pkg::MODE_CLEAR, 0, 0, '0);
		send(nmag_pkg::MODE_READ, 0, 0, '0);
		send(nmag_pkg::MODE_READ, 255, 79, '0);
		random_requests(320);

		// second setting: widest eps, starts at the opposite extremes
		settle();
		send_idle = 86;
		recv_idle = 38;
		write_reg(nmag_pkg::CFG_EPS, 32'hFFFF);
		write_reg(nmag_pkg::CFG_MIN, 32'h8000_0000);
		write_reg(nmag_pkg::CFG_MAX, 32'h7FFF_FFFF);
		send(nmag_pkg::MODE_CLEAR, 0, 0, '0);
		random_requests(320);

		// third setting: zero eps; long receiver stall once the clear is done
		settle();
		send_idle = 0;
		recv_idle = 0;
		write_reg(nmag_pkg::CFG_EPS, 32'd0);
		write_reg(nmag_pkg::CFG_MIN, 32'h7FFF_FFFF);
		write_reg(nmag_pkg::CFG_MAX, 32'h8000_0000);
		send(nmag_pkg::MODE_CLEAR, 0, 0, '0);
		for (int i = 0; i < 12; i++) begin
			send(nmag_pkg::MODE_READ, i % 4, i % 3, '0);
			if (i == 0) hold_off = 400;
		end
		random_requests(330);

		// short burst on one entry: large sums divided by a growing edge count
		for (int i = 0; i < 24; i++) send(nmag_pkg::MODE_ACC, 7, 0, 32'h7FFF_FFFF);
		send(nmag_pkg::MODE_ACC, 7, 0, 32'h8000_0000);
		send(nmag_pkg::MODE_READ, 7, 0, '0);
		send(nmag_pkg::MODE_READ, 7, 80, '0);

		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);

		$display("%0d requests sent over three pacing profiles and three register settings,",
			sent);
		$display("%0d readouts compared, including square-sum saturation and bad indexes",
			checked);
		if (fail_count == 0) begin
			$display("neighbour_mean_min_max_std_aggregator verification clean");
		end else begin
			$display("neighbour_mean_min_max_std_aggregator verification failed");
		end
		$finish;
	end

endmodule

FILE: neighbour_mean_min_max_std_aggregator.f
+incdir+design
design/nmag_pkg.sv
design/nmag_ram.sv
design/neighbour_mean_min_max_std_aggregator.sv
test/aggregator_checker.sv
test/testbench.sv
